// ----- rtl/core/psw_pkg.sv -----
package psw_pkg;

  localparam int SearchRange = 1;
  localparam int PicWidth = 256;
  localparam int PicHeight = 256;
  localparam int UseW = (PicWidth < 256) ? PicWidth : 256;
  localparam int UseH = (PicHeight < 256) ? PicHeight : 256;
  localparam int WinSide = 2 * SearchRange + 1;
  localparam int WinCount = WinSide * WinSide;
  localparam int WinW = $clog2(WinCount + 1);
  localparam int OffW = 4;

  localparam logic [62:0] AccMax = {63{1'b1}};

  localparam logic [2:0] RegShift0 = 3'd0;
  localparam logic [2:0] RegShift1 = 3'd1;
  localparam logic [2:0] RegShift2 = 3'd2;
  localparam logic [2:0] RegShift3 = 3'd3;
  localparam logic [2:0] RegWeight0 = 3'd4;
  localparam logic [2:0] RegWeight1 = 3'd5;
  localparam logic [2:0] RegWeight2 = 3'd6;
  localparam logic [2:0] RegWeight3 = 3'd7;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTest = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] comp0;
    logic [15:0] comp1;
    logic [15:0] comp2;
    logic [15:0] comp3;
    logic        row_end;
  } in_word_t;

  typedef struct packed {
    logic [62:0] row_sum0;
    logic [62:0] row_sum1;
    logic [62:0] row_sum2;
    logic [62:0] row_sum3;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted word
    logic load_wr;   // write reference pixel
    logic rd_issue;  // issue a window read
    logic sq_en;     // difference/square stage valid
    logic err_en;    // weighted error stage valid
    logic cmp_en;    // compare stage valid
    logic first;     // compare stage holds the first candidate
    logic accum;     // add winner to accumulators
    logic emit;      // load output register and clear sums
  } psw_cmd_t;

  typedef struct packed {
    logic is_test;
    logic row_end;
    logic in_pic;
  } psw_stat_t;

  function automatic logic [7:0] clamp_coord(input logic [7:0] p, input logic signed [3:0] d,
                                             input int size);
    logic signed [9:0] v;
    v = $signed({2'b00, p}) + 10'(d);
    if (v < 0) return 8'd0;
    if (v > 10'(size - 1)) return 8'(size - 1);
    return v[7:0];
  endfunction

endpackage

// ----- rtl/core/psw_ram.sv -----
module psw_ram #(
  parameter int Width = 64,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/psw_ctrl.sv -----
module psw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  psw_pkg::psw_stat_t   stat,
  output psw_pkg::psw_cmd_t    cmd,
  output logic [psw_pkg::WinW-1:0] win_idx
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DISP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [psw_pkg::WinW-1:0] win_idx_next;
  // pipeline valid bits: read, square, error, compare
  logic v_rd, v_sq, v_err, v_cmp;
  logic f_rd, f_sq, f_err;
  logic reads_done;

  assign reads_done = (win_idx == psw_pkg::WinW'(psw_pkg::WinCount));
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    win_idx_next = win_idx;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (!stat.is_test) begin
          cmd.load_wr = stat.in_pic;
          state_next = ST_IDLE;
        end else begin
          win_idx_next = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!reads_done) begin
          cmd.rd_issue = 1'b1;
          win_idx_next = win_idx + 1'b1;
        end else if (!v_rd && !v_sq && !v_err && !v_cmp) begin
          cmd.accum = 1'b1;
          state_next = stat.row_end ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        // hold until the previous result word has left
        if (!out_valid || !out_stall) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    cmd.sq_en = v_rd;
    cmd.err_en = v_sq;
    cmd.cmp_en = v_err;
    cmd.first = f_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      win_idx <= '0;
      {v_rd, v_sq, v_err, v_cmp} <= '0;
      {f_rd, f_sq, f_err} <= '0;
    end else begin
      state <= state_next;
      win_idx <= win_idx_next;
      v_rd <= cmd.rd_issue;
      f_rd <= cmd.rd_issue && (win_idx == '0);
      v_sq <= v_rd;
      f_sq <= f_rd;
      v_err <= v_sq;
      f_err <= f_sq;
      v_cmp <= v_err;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_win_bound: assert property (@(posedge clk) disable iff (rst)
    win_idx <= psw_pkg::WinW'(psw_pkg::WinCount)) else $error("window index overrun");
  a_accum_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.accum |-> (!v_rd && !v_sq && !v_err)) else $error("accumulate before drain");
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !cmd.emit) else $error("double emit");

endmodule

// ----- rtl/core/psw_dp.sv -----
module psw_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  psw_pkg::in_word_t         in_word,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [16:0]               cfg_data,
  input  psw_pkg::psw_cmd_t         cmd,
  input  logic [psw_pkg::WinW-1:0]  win_idx,
  output psw_pkg::psw_stat_t        stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output psw_pkg::out_word_t        out_word
);

  psw_pkg::in_word_t cur;
  logic signed [16:0] shift [4];
  logic [15:0] weight [4];
  logic signed [17:0] tst [4];

  logic [7:0] rx, ry;
  logic [3:0] wx, wy;
  logic [63:0] rd_data;

  logic [35:0] sq [4];
  logic [51:0] wsq [4];
  logic [35:0] sq_e [4];
  logic [53:0] err;
  logic [35:0] sq_c [4];
  logic [53:0] best_err;
  logic [35:0] best_sq [4];
  logic [62:0] acc [4];
  logic better;
  logic cmp_live, cmp_first;

  // window position from the scan index: constant lookup over the window
  always_comb begin
    wy = '0;
    wx = '0;
    for (int i = 0; i < psw_pkg::WinCount; i++) begin
      if (win_idx == psw_pkg::WinW'(i)) begin
        wy = 4'(i / psw_pkg::WinSide);
        wx = 4'(i % psw_pkg::WinSide);
      end
    end
  end

  assign ry = psw_pkg::clamp_coord(cur.pos_y,
                4'(wy) - 4'(psw_pkg::SearchRange), psw_pkg::UseH);
  assign rx = psw_pkg::clamp_coord(cur.pos_x,
                4'(wx) - 4'(psw_pkg::SearchRange), psw_pkg::UseW);

  assign stat.is_test = (cur.func == psw_pkg::FuncTest);
  assign stat.row_end = cur.row_end;
  assign stat.in_pic = (9'(cur.pos_x) < 9'(psw_pkg::UseW)) &&
                       (9'(cur.pos_y) < 9'(psw_pkg::UseH));

  psw_ram #(.Width(64), .Depth(65536)) u_pic (
    .clk    (clk),
    .wr_en  (cmd.load_wr),
    .wr_addr({cur.pos_y, cur.pos_x}),
    .wr_data({cur.comp3, cur.comp2, cur.comp1, cur.comp0}),
    .rd_addr({ry, rx}),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        shift[c] <= '0;
        weight[c] <= (c == 3) ? 16'd0 : 16'd1;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        psw_pkg::RegShift0:  shift[0] <= cfg_data;
        psw_pkg::RegShift1:  shift[1] <= cfg_data;
        psw_pkg::RegShift2:  shift[2] <= cfg_data;
        psw_pkg::RegShift3:  shift[3] <= cfg_data;
        psw_pkg::RegWeight0: weight[0] <= cfg_data[15:0];
        psw_pkg::RegWeight1: weight[1] <= cfg_data[15:0];
        psw_pkg::RegWeight2: weight[2] <= cfg_data[15:0];
        psw_pkg::RegWeight3: weight[3] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= in_word;
    end
  end

  always_comb begin
    tst[0] = $signed({2'b00, cur.comp0}) + 18'(shift[0]);
    tst[1] = $signed({2'b00, cur.comp1}) + 18'(shift[1]);
    tst[2] = $signed({2'b00, cur.comp2}) + 18'(shift[2]);
    tst[3] = $signed({2'b00, cur.comp3}) + 18'(shift[3]);
  end

  // candidate pipeline: square, weighted error, compare
  always_ff @(posedge clk) begin
    logic signed [18:0] d;
    logic [17:0] a;
    if (cmd.sq_en) begin
      for (int c = 0; c < 4; c++) begin
        d = 19'(tst[c]) - $signed({3'b000, rd_data[16*c +: 16]});
        a = d[18] ? 18'(-d) : d[17:0];
        sq[c] <= a * a;
      end
    end
    if (cmd.err_en) begin
      for (int c = 0; c < 4; c++) begin
        wsq[c] <= sq[c][35:0] * weight[c];
        sq_e[c] <= sq[c];
      end
    end
    if (cmd.cmp_en) begin
      err <= 54'(wsq[0]) + 54'(wsq[1]) + 54'(wsq[2]) + 54'(wsq[3]);
      for (int c = 0; c < 4; c++) sq_c[c] <= sq_e[c];
    end
  end

  // compare stage runs in the cycle after cmp_en
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live <= 1'b0;
      cmp_first <= 1'b0;
    end else begin
      cmp_live <= cmd.cmp_en;
      cmp_first <= cmd.first;
    end
  end

  assign better = cmp_first || (err < best_err);

  always_ff @(posedge clk) begin
    if (cmp_live && better) begin
      best_err <= err;
      for (int c = 0; c < 4; c++) best_sq[c] <= sq_c[c];
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] s;
    if (rst) begin
      for (int c = 0; c < 4; c++) acc[c] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.accum) begin
        for (int c = 0; c < 4; c++) begin
          s = 64'(acc[c]) + 64'(best_sq[c]);
          acc[c] <= (s > 64'(psw_pkg::AccMax)) ? psw_pkg::AccMax : s[62:0];
        end
      end
      if (cmd.emit) begin
        out_word <= '{acc[0], acc[1], acc[2], acc[3]};
        out_valid <= 1'b1;
        for (int c = 0; c < 4; c++) acc[c] <= '0;
      end
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall)) else $error("output overwritten");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accum && cmd.emit)) else $error("accumulate and emit together");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (acc[0] == '0 && acc[3] == '0)) else $error("sums not cleared");

endmodule

// ----- rtl/core/pixel_shift_window_distance.sv -----
// Load word: captured on accept, written to the picture store, then the next accept.
// Test word: WinCount window reads (3x3 window), a drain, accumulate, an emit on row_end;
// one window read a cycle from the two-port picture store, then a 4-stage drain.
// One word in flight at a time; a row sum is valid after the emit of a row_end test word.
// rst (synchronous) clears sums, registers to defaults, control state;
// the picture store holds no reset and must be written before it is read.
module pixel_shift_window_distance (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psw_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psw_pkg::out_word_t   out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [16:0]          cfg_data
);

  psw_pkg::psw_cmd_t cmd;
  psw_pkg::psw_stat_t stat;
  logic [psw_pkg::WinW-1:0] win_idx;

  psw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd),
    .win_idx  (win_idx)
  );

  psw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .win_idx  (win_idx),
    .stat     (stat),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_word (out_data)
  );

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;
  localparam int SettleCycles = 30;
  localparam int HoldCycles = 400;

  class row_sum_board;
    logic [63:0] picture [65536];
    logic [62:0] row_acc [4];
    logic signed [16:0] shift [4];
    logic [15:0] weight [4];
    psw_pkg::out_word_t sums_q [$];
    int errors;

    function new();
      for (int c = 0; c < 4; c++) begin
        row_acc[c] = '0;
        shift[c] = '0;
        weight[c] = 16'd1;
      end
      weight[3] = 16'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [16:0] val);
      if (idx < psw_pkg::RegWeight0) shift[idx] = val;
      else weight[idx - psw_pkg::RegWeight0] = val[15:0];
    endfunction

    function int clamp(int v, int size);
      if (v < 0) return 0;
      if (v > size - 1) return size - 1;
      return v;
    endfunction

    function logic [62:0] sat_add(logic [62:0] a, longint unsigned b);
      longint unsigned s;
      s = 64'(a) + b;
      if (s > 64'(psw_pkg::AccMax)) return psw_pkg::AccMax;
      return s[62:0];
    endfunction

    task report(string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    // Update state for an accepted input word; queue a row sum on a test word's row_end.
    function void note_word(psw_pkg::in_word_t w);
      longint tst [4];
      longint unsigned sq [4];
      longint unsigned best_sq [4];
      longint unsigned best_err, err;
      logic [15:0] cv [4];
      logic [63:0] pel;
      longint d;
      int ry, rx;
      bit have;
      psw_pkg::out_word_t o;
      cv[0] = w.comp0; cv[1] = w.comp1; cv[2] = w.comp2; cv[3] = w.comp3;
      if (w.func == psw_pkg::FuncLoad) begin
        if (w.pos_x < psw_pkg::UseW && w.pos_y < psw_pkg::UseH)
          picture[{w.pos_y, w.pos_x}] = {cv[3], cv[2], cv[1], cv[0]};
        return;
      end
      have = 0;
      best_err = 0;
      for (int c = 0; c < 4; c++) begin
        tst[c] = longint'(cv[c]) + longint'(shift[c]);
        best_sq[c] = 0;
      end
      for (int dy = -psw_pkg::SearchRange; dy <= psw_pkg::SearchRange; dy++) begin
        ry = clamp(int'(w.pos_y) + dy, psw_pkg::UseH);
        for (int dx = -psw_pkg::SearchRange; dx <= psw_pkg::SearchRange; dx++) begin
          rx = clamp(int'(w.pos_x) + dx, psw_pkg::UseW);
          pel = picture[ry * 256 + rx];
          err = 0;
          for (int c = 0; c < 4; c++) begin
            d = tst[c] - longint'(pel[16*c +: 16]);
            if (d < 0) d = -d;
            sq[c] = d * d;
            err += sq[c] * weight[c];
          end
          if (!have || err < best_err) begin
            have = 1;
            best_err = err;
            best_sq = sq;
          end
        end
      end
      for (int c = 0; c < 4; c++) row_acc[c] = sat_add(row_acc[c], best_sq[c]);
      if (w.row_end) begin
        o = '{row_acc[0], row_acc[1], row_acc[2], row_acc[3]};
        sums_q.push_back(o);
        for (int c = 0; c < 4; c++) row_acc[c] = '0;
      end
    endfunction

    task check_sum(psw_pkg::out_word_t got);
      psw_pkg::out_word_t exp;
      if (sums_q.size() == 0) begin
        report($sformatf("row sum with none pending: %h", got));
        return;
      end
      exp = sums_q.pop_front();
      if (got.row_sum0 !== exp.row_sum0)
        report($sformatf("row_sum0 got %0d want %0d", got.row_sum0, exp.row_sum0));
      if (got.row_sum1 !== exp.row_sum1)
        report($sformatf("row_sum1 got %0d want %0d", got.row_sum1, exp.row_sum1));
      if (got.row_sum2 !== exp.row_sum2)
        report($sformatf("row_sum2 got %0d want %0d", got.row_sum2, exp.row_sum2));
      if (got.row_sum3 !== exp.row_sum3)
        report($sformatf("row_sum3 got %0d want %0d", got.row_sum3, exp.row_sum3));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  psw_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psw_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  row_sum_board sb;
  bit written [65536];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int words_sent = 0;

  pixel_shift_window_distance i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("pixel_shift_window_distance: mismatch");
      $finish;
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering
  always @(posedge clk) begin
    if (hold_go) hold_left <= HoldCycles;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (hold_left > 0 || hold_go) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_sum(out_data);
  end

  task automatic send_word(psw_pkg::in_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
    words_sent++;
  endtask

  function automatic psw_pkg::in_word_t rand_word(logic func, int x, int y, logic re);
    psw_pkg::in_word_t w;
    w.func = func;
    w.pos_x = x[7:0];
    w.pos_y = y[7:0];
    w.comp0 = 16'($urandom);
    w.comp1 = 16'($urandom);
    w.comp2 = 16'($urandom);
    w.comp3 = 16'($urandom);
    w.row_end = re;
    return w;
  endfunction

  task automatic load_pixel(int x, int y);
    send_word(rand_word(psw_pkg::FuncLoad, x, y, 1'($urandom_range(1))));
    written[y * 256 + x] = 1;
  endtask

  // load whatever part of the clamped window is still unwritten
  task automatic fill_window(int x, int y);
    int rx, ry;
    for (int dy = -psw_pkg::SearchRange; dy <= psw_pkg::SearchRange; dy++)
      for (int dx = -psw_pkg::SearchRange; dx <= psw_pkg::SearchRange; dx++) begin
        ry = sb.clamp(y + dy, psw_pkg::UseH);
        rx = sb.clamp(x + dx, psw_pkg::UseW);
        if (!written[ry * 256 + rx]) load_pixel(rx, ry);
      end
  endtask

  task automatic test_pixel(psw_pkg::in_word_t w);
    fill_window(int'(w.pos_x), int'(w.pos_y));
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.sums_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(logic [16:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(i[2:0], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int edge_or_rand();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(255);
  endfunction

  task automatic random_words(int count);
    int stop_at, x, y, run;
    psw_pkg::in_word_t w;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // noise: stray loads, some overwriting
        load_pixel($urandom_range(255), $urandom_range(255));
      end else begin
        y = edge_or_rand();
        x = edge_or_rand();
        run = $urandom_range(1, 10);
        for (int k = 0; k < run && x < 256; k++) begin
          w = rand_word(psw_pkg::FuncTest, x, y,
                        (k == run - 1) || ($urandom_range(15) == 0));
          test_pixel(w);
          x++;
        end
      end
    end
  endtask

  task automatic directed_words();
    psw_pkg::in_word_t w;
    w = '{psw_pkg::FuncTest, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0};
    test_pixel(w);
    w = '{psw_pkg::FuncTest, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
    test_pixel(w);
    w = '{psw_pkg::FuncTest, 8'd255, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1};
    test_pixel(w);
    w = '{psw_pkg::FuncTest, 8'd0, 8'd255, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0};
    test_pixel(w);
    // a load marked row_end must not emit
    send_word('{psw_pkg::FuncLoad, 8'd1, 8'd254, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                1'b1});
    w = '{psw_pkg::FuncTest, 8'd1, 8'd254, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
    test_pixel(w);
    w = '{psw_pkg::FuncTest, 8'd128, 8'd64, 16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 1'b1};
    test_pixel(w);
  endtask

  function automatic logic [16:0] rand_shift();
    case ($urandom_range(3))
      0: return 17'h10001;
      1: return 17'h0FFFF;
      default: return 17'(int'($urandom_range(131070)) - 65535);
    endcase
  endfunction

  task automatic run_phase(int s_pct, int r_pct, int kind, int count);
    logic [16:0] v [8];
    for (int c = 0; c < 4; c++) begin
      case (kind)
        0: begin v[c] = '0; v[c+4] = (c == 3) ? 17'd0 : 17'd1; end
        1: begin v[c] = 17'h0FFFF; v[c+4] = 17'h0FFFF; end
        2: begin v[c] = 17'h10001; v[c+4] = 17'd0; end
        default: begin
          v[c] = rand_shift();
          v[c+4] = ($urandom_range(3) == 0) ? 17'd0 : 17'($urandom_range(65535));
        end
      endcase
    end
    write_regs(v);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    random_words(count);
    wait_idle();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_words();
    wait_idle();
    run_phase(0, 0, 0, 250);
    run_phase(57, 0, 1, 250);
    run_phase(0, 57, 2, 250);
    run_phase(31, 31, 3, 250);
    // fill the block while the receiver holds off
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_words(150);
    wait_idle();
    run_phase(0, 0, 3, 250);
    run_phase(31, 31, 3, 250);
    if (sb.errors == 0) begin
      $display("pixel_shift_window_distance: match");
    end else begin
      $display("pixel_shift_window_distance: mismatch");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/psw_pkg.sv
rtl/core/psw_ram.sv
rtl/core/psw_ctrl.sv
rtl/core/psw_dp.sv
rtl/core/pixel_shift_window_distance.sv
test/tb.sv
